>>> src/btfa_pkg.sv
`timescale 1ns / 1ps

package btfa_pkg;

  // heap geometry
  localparam int HEAP_BYTES = 8192;
  localparam int HEAP_LIMIT = (HEAP_BYTES / 8) * 8;
  localparam int HEAP_WORDS = HEAP_LIMIT / 8;
  localparam int WORD_AW    = $clog2(HEAP_WORDS);

  // a tag holds a size up to the heap limit, in-use flag in bit 0
  localparam int TAG_W = $clog2(HEAP_LIMIT + 1);

  localparam int FIELD_W   = 13;
  localparam int TAG_BYTES = 8;
  localparam int MIN_SPLIT = 3 * TAG_BYTES;
  localparam int PAD_BYTES = TAG_BYTES + 2 * TAG_BYTES;
  localparam int NEED_W    = $clog2((1 << FIELD_W) - 1 + PAD_BYTES + 1);

  // datapath width: covers offsets, sizes, padded requests and one carry
  localparam int BASE_W = (TAG_W > NEED_W) ? TAG_W : NEED_W;
  localparam int WIDE_W = ((BASE_W > FIELD_W) ? BASE_W : FIELD_W) + 1;

  localparam logic [WIDE_W-1:0] LIMIT_W     = WIDE_W'(HEAP_LIMIT);
  localparam logic [WIDE_W-1:0] TAG_BYTES_W = WIDE_W'(TAG_BYTES);
  localparam logic [WIDE_W-1:0] MIN_SPLIT_W = WIDE_W'(MIN_SPLIT);
  localparam logic [WIDE_W-1:0] PAD_BYTES_W = WIDE_W'(PAD_BYTES);
  localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(HEAP_WORDS - 1);

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] request_bytes;
    logic [FIELD_W-1:0] payload_offset;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] granted_offset;
  } out_word_t;

  typedef struct packed {
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [WIDE_W-1:0] res;
    logic              neg;
  } alu_rsp_t;

  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] addr;
    logic [TAG_W-1:0]   wdata;
  } mem_req_t;

endpackage

>>> src/btfa_ram.sv
`timescale 1ns / 1ps

module btfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/btfa_alu.sv
`timescale 1ns / 1ps

module btfa_alu (
  input  btfa_pkg::alu_req_t req,
  output btfa_pkg::alu_rsp_t rsp
);

  import btfa_pkg::*;

  logic [WIDE_W:0] full;

  // one adder, also used for compares through the borrow
  always_comb begin
    if (req.sub) begin
      full = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      full = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res = full[WIDE_W-1:0];
    rsp.neg = req.sub & full[WIDE_W];
  end

endmodule

>>> src/btfa_seq.sv
`timescale 1ns / 1ps

module btfa_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  btfa_pkg::in_word_t            cmd,
  input  logic                          result_take,
  output logic                          idle,
  output logic                          done,
  output btfa_pkg::out_word_t           result,
  output btfa_pkg::alu_req_t            alu_req,
  input  btfa_pkg::alu_rsp_t            alu_rsp,
  output btfa_pkg::mem_req_t            mem_req,
  input  logic [btfa_pkg::TAG_W-1:0]    mem_rdata
);

  import btfa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_FIT  = 4'd3;
  localparam logic [3:0] S_WA   = 4'd4;
  localparam logic [3:0] S_WB   = 4'd5;
  localparam logic [3:0] S_WC   = 4'd6;
  localparam logic [3:0] S_WD   = 4'd7;
  localparam logic [3:0] S_FH   = 4'd8;
  localparam logic [3:0] S_FF   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic              act_r, act_nxt;
  logic              status_r, status_nxt;
  logic [WIDE_W-1:0] need_r, need_nxt;
  logic [WIDE_W-1:0] cur_r, cur_nxt;
  logic [WIDE_W-1:0] end_r, end_nxt;
  logic [WIDE_W-1:0] mid_r, mid_nxt;
  logic [WIDE_W-1:0] gofs_r, gofs_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [TAG_W-1:0]  rest_r, rest_nxt;
  logic              split_r, split_nxt;
  logic              ovr_r, ovr_nxt;
  logic              vld0_r, vld0_nxt;
  logic              vldl_r, vldl_nxt;

  logic [WORD_AW-1:0] cur_word;
  logic [WORD_AW-1:0] res_word;
  logic [TAG_W-1:0]   tag_v;
  logic [WIDE_W-1:0]  size_v;
  logic [WIDE_W-1:0]  size_r;
  logic [TAG_W-1:0]   hdr_a;
  logic [TAG_W-1:0]   rest_tag;
  logic [TAG_W-1:0]   free_tag;
  logic [WIDE_W-1:0]  req_al;
  logic [WIDE_W-1:0]  pay_al;

  assign cur_word = cur_r[WORD_AW+2:3];
  assign res_word = alu_rsp.res[WORD_AW+2:3];

  // head and tail words read as the initial free block until first written
  assign tag_v  = ovr_r ? TAG_W'(HEAP_LIMIT) : mem_rdata;
  assign size_v = WIDE_W'({tag_v[TAG_W-1:1], 1'b0});
  assign size_r = WIDE_W'({tag_r[TAG_W-1:1], 1'b0});

  assign hdr_a    = split_r ? {need_r[TAG_W-1:1], 1'b1} : {tag_r[TAG_W-1:1], 1'b1};
  assign rest_tag = {rest_r[TAG_W-1:1], 1'b0};
  assign free_tag = {tag_r[TAG_W-1:1], 1'b0};

  assign req_al = WIDE_W'({cmd.request_bytes[FIELD_W-1:3], 3'b000});
  assign pay_al = WIDE_W'({cmd.payload_offset[FIELD_W-1:3], 3'b000});

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    status_nxt = status_r;
    need_nxt   = need_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    mid_nxt    = mid_r;
    gofs_nxt   = gofs_r;
    tag_nxt    = tag_r;
    rest_nxt   = rest_r;
    split_nxt  = split_r;
    ovr_nxt    = ovr_r;
    alu_req    = '0;
    mem_req    = '0;
    mem_req.addr = cur_word;

    unique case (state_r)
      S_IDLE: begin
        // padded size for allocate, header offset for free
        alu_req.a   = (cmd.action == ACT_FREE) ? pay_al : req_al;
        alu_req.b   = (cmd.action == ACT_FREE) ? TAG_BYTES_W : PAD_BYTES_W;
        alu_req.sub = (cmd.action == ACT_FREE);
        if (start) begin
          act_nxt    = cmd.action;
          status_nxt = ST_DONE;
          if (cmd.action == ACT_FREE) begin
            if (cmd.payload_offset < FIELD_W'(TAG_BYTES)) begin
              state_nxt = S_DONE;
            end else begin
              cur_nxt   = alu_rsp.res;
              state_nxt = S_RD;
            end
          end else begin
            need_nxt  = alu_rsp.res;
            cur_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        alu_req.a = cur_r;
        alu_req.b = TAG_BYTES_W;
        gofs_nxt  = alu_rsp.res;
        if (cur_r >= LIMIT_W) begin
          status_nxt = (act_r == ACT_ALLOC) ? ST_NOFIT : ST_DONE;
          state_nxt  = S_DONE;
        end else begin
          ovr_nxt   = ((cur_word == '0) && !vld0_r) || ((cur_word == LAST_WORD) && !vldl_r);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        alu_req.a = cur_r;
        alu_req.b = size_v;
        tag_nxt   = tag_v;
        end_nxt   = alu_rsp.res;
        if (act_r == ACT_FREE) begin
          state_nxt = S_FH;
        end else if (size_v == '0 || size_v[2:0] != 3'b000 || alu_rsp.res > LIMIT_W) begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_DONE;
        end else if (tag_v[0]) begin
          cur_nxt   = alu_rsp.res;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        alu_req.a   = size_r;
        alu_req.b   = need_r;
        alu_req.sub = 1'b1;
        if (alu_rsp.neg) begin
          cur_nxt   = end_r;
          state_nxt = S_RD;
        end else begin
          rest_nxt  = alu_rsp.res[TAG_W-1:0];
          split_nxt = (alu_rsp.res >= MIN_SPLIT_W);
          state_nxt = S_WA;
        end
      end
      S_WA: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = hdr_a;
        alu_req.a     = cur_r;
        alu_req.b     = need_r;
        mid_nxt       = alu_rsp.res;
        state_nxt     = S_WB;
      end
      S_WB: begin
        alu_req.a     = split_r ? mid_r : end_r;
        alu_req.b     = TAG_BYTES_W;
        alu_req.sub   = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = res_word;
        mem_req.wdata = hdr_a;
        state_nxt     = split_r ? S_WC : S_DONE;
      end
      S_WC: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = mid_r[WORD_AW+2:3];
        mem_req.wdata = rest_tag;
        state_nxt     = S_WD;
      end
      S_WD: begin
        alu_req.a     = end_r;
        alu_req.b     = TAG_BYTES_W;
        alu_req.sub   = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = res_word;
        mem_req.wdata = rest_tag;
        state_nxt     = S_DONE;
      end
      S_FH: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = free_tag;
        // footer only for a nonzero size that ends inside the heap
        if (tag_r[TAG_W-1:1] != '0 && end_r <= LIMIT_W) begin
          state_nxt = S_FF;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FF: begin
        alu_req.a     = end_r;
        alu_req.b     = TAG_BYTES_W;
        alu_req.sub   = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = res_word;
        mem_req.wdata = free_tag;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (result_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    vld0_nxt = vld0_r | (mem_req.we && mem_req.addr == '0);
    vldl_nxt = vldl_r | (mem_req.we && mem_req.addr == LAST_WORD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld0_r  <= 1'b0;
      vldl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld0_r  <= vld0_nxt;
      vldl_r  <= vldl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    status_r <= status_nxt;
    need_r   <= need_nxt;
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    mid_r    <= mid_nxt;
    gofs_r   <= gofs_nxt;
    tag_r    <= tag_nxt;
    rest_r   <= rest_nxt;
    split_r  <= split_nxt;
    ovr_r    <= ovr_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);

  assign result.status         = status_r;
  assign result.granted_offset = (act_r == ACT_ALLOC && status_r == ST_DONE)
                                 ? gofs_r[FIELD_W-1:0] : '0;

endmodule

>>> src/boundary_tag_first_fit_allocator_core.sv
`timescale 1ns / 1ps

// channel  | ports                          | word
// ---------+--------------------------------+---------------------------------------
// input    | in_valid, in_ready, in_word    | action, request_bytes, payload_offset
// result   | out_valid, out_ready, out_word | status, granted_offset
//
// one item at a time; in_ready is high only while the sequencer is idle
// allocate: setup, a tag read and check per in-use block passed, and a read, check
//   and fit compare per free block (the one that fits included), then header and
//   footer writes, plus the remainder's header and footer on a split, then the
//   result is posted; a walk that reaches the heap end with no fit ends there,
//   a corrupt tag ends the walk after its check
// free: setup, tag read, check, header write, footer write if any, post; an offset
//   below 8 skips to post; one tag memory port and one adder serve the whole walk
// rst_n is synchronous; no clearing pass, the first and last tag words read
//   as one free block spanning the heap until first written
// a finished result sits in the output register, so a stalled out_ready only
//   blocks the next item once a second result is ready

module boundary_tag_first_fit_allocator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btfa_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output btfa_pkg::out_word_t out_word
);

  import btfa_pkg::*;

  logic      seq_idle;
  logic      seq_done;
  logic      start;
  logic      take;
  out_word_t seq_result;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  mem_req_t  mem_req;
  logic [TAG_W-1:0] mem_rdata;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  // sequencer owns the walk; output register parts the result side
  assign in_ready = seq_idle;
  assign start    = in_valid & seq_idle;
  assign take     = !out_valid_r || out_ready;

  btfa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd         (in_word),
    .result_take (take),
    .idle        (seq_idle),
    .done        (seq_done),
    .result      (seq_result),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  // shared adder for offsets, sizes and fit compares
  btfa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // tag words, one per 8-byte word of the heap
  btfa_ram #(
    .WIDTH (TAG_W),
    .DEPTH (HEAP_WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (seq_done && take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && take) begin
      out_word_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> src/btfa_chk.sv
`timescale 1ns / 1ps

module btfa_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input btfa_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input btfa_pkg::out_word_t out_word
);

  import btfa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // no offset with a no-fit status
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_NOFIT |-> out_word.granted_offset == '0)
    else $error("offset given with no-fit status");

  // granted payloads sit on an 8-byte word
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.granted_offset[2:0] == 3'b000)
    else $error("unaligned payload offset");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind boundary_tag_first_fit_allocator_core btfa_chk u_chk (.*);

>>> test/heap_grant_checker.sv
`timescale 1ns / 1ps

module heap_grant_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  btfa_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  btfa_pkg::out_word_t out_word,
  output int                  mismatches,
  output int                  owed
);
  import btfa_pkg::*;

  // shadow heap: one tag per 8-byte word, plus a flag for words ever written
  logic [TAG_W-1:0] tag_mem  [HEAP_WORDS];
  bit               tag_seen [HEAP_WORDS];
  out_word_t        owed_results [$];

  task automatic note_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int tag_size(int off);
    return int'(tag_mem[off / TAG_BYTES]) & ~1;
  endfunction

  function automatic void put_tag(int off, int value);
    if (off >= 0 && off < HEAP_LIMIT) begin
      tag_mem[off / TAG_BYTES]  = TAG_W'(value);
      tag_seen[off / TAG_BYTES] = 1'b1;
    end
  endfunction

  // header always, footer only when it lands inside the heap
  function automatic void put_block(int start, int size, bit used);
    put_tag(start, size | int'(used));
    if (size >= TAG_BYTES && size <= HEAP_LIMIT && start <= HEAP_LIMIT - size)
      put_tag(start + size - TAG_BYTES, size | int'(used));
  endfunction

  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t r;
    int        pay, req, needed, cur, tag, size;
    r.status         = ST_DONE;
    r.granted_offset = '0;
    if (w.action == ACT_FREE) begin
      pay = int'(w.payload_offset);
      // below 8 there is no header to clear
      if (pay >= TAG_BYTES) begin
        cur = (pay & ~7) - TAG_BYTES;
        put_block(cur, tag_size(cur), 1'b0);
      end
      return r;
    end
    req    = int'(w.request_bytes);
    needed = req + (TAG_BYTES - (req % TAG_BYTES)) + 2 * TAG_BYTES;
    cur    = 0;
    while (cur < HEAP_LIMIT) begin
      tag  = int'(tag_mem[cur / TAG_BYTES]);
      size = tag & ~1;
      // corrupt tag ends the walk
      if (size == 0 || (size % TAG_BYTES) != 0 || size > HEAP_LIMIT - cur) break;
      if (tag[0] == 1'b0 && size >= needed) begin
        if (size - needed >= MIN_SPLIT) begin
          put_block(cur, needed, 1'b1);
          put_block(cur + needed, size - needed, 1'b0);
        end else begin
          put_block(cur, size, 1'b1);
        end
        r.granted_offset = FIELD_W'(cur + TAG_BYTES);
        return r;
      end
      cur += size;
    end
    r.status = ST_NOFIT;
    return r;
  endfunction

  // every header that a walk from offset 0 reaches has been written
  function automatic bit chain_readable();
    int cur, size;
    cur = 0;
    while (cur < HEAP_LIMIT) begin
      if (!tag_seen[cur / TAG_BYTES]) return 1'b0;
      size = tag_size(cur);
      if (size == 0 || size > HEAP_LIMIT - cur) return 1'b1;
      cur += size;
    end
    return 1'b1;
  endfunction

  // try the free on the shadow heap, then roll it back
  function automatic bit free_keeps_heap_readable(int pay);
    logic [TAG_W-1:0] saved_tag  [HEAP_WORDS];
    bit               saved_seen [HEAP_WORDS];
    bit               ok;
    int               start;
    if (pay < TAG_BYTES) return 1'b1;
    start = (pay & ~7) - TAG_BYTES;
    if (!tag_seen[start / TAG_BYTES]) return 1'b0;
    saved_tag  = tag_mem;
    saved_seen = tag_seen;
    put_block(start, tag_size(start), 1'b0);
    ok       = chain_readable();
    tag_mem  = saved_tag;
    tag_seen = saved_seen;
    return ok;
  endfunction

  // payload of a random in-use block, or the word after a random footer
  function automatic int pick_block_payload(bit at_footer);
    int spots [$];
    int cur, size;
    cur = 0;
    while (cur < HEAP_LIMIT) begin
      size = tag_size(cur);
      if (size == 0 || size > HEAP_LIMIT - cur) break;
      if (at_footer) begin
        if (cur + size < HEAP_LIMIT) spots.push_back(cur + size);
      end else if (tag_mem[cur / TAG_BYTES][0]) begin
        spots.push_back(cur + TAG_BYTES);
      end
      cur += size;
    end
    if (spots.size() == 0) return 0;
    return spots[$urandom_range(0, spots.size() - 1)];
  endfunction

  always @(posedge clk) begin : track
    out_word_t want;
    if (!rst_n) begin
      foreach (tag_mem[i]) begin
        tag_mem[i]  = '0;
        tag_seen[i] = 1'b0;
      end
      put_block(0, HEAP_LIMIT, 1'b0);
      owed_results.delete();
      owed       = 0;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          note_mismatch($sformatf("word status %0b offset %0d with nothing expected",
                                  out_word.status, out_word.granted_offset));
        end else begin
          want = owed_results.pop_front();
          if (out_word.status !== want.status)
            note_mismatch($sformatf("status %0b, expected %0b", out_word.status,
                                    want.status));
          if (out_word.granted_offset !== want.granted_offset)
            note_mismatch($sformatf("granted_offset %0d, expected %0d",
                                    out_word.granted_offset, want.granted_offset));
        end
      end
      if (in_valid && in_ready) owed_results.push_back(heap_apply(in_word));
      owed = owed_results.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import btfa_pkg::*;

  localparam int N_RANDOM = 1000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int mismatches;
  int owed;
  int results_taken = 0;
  int send_run      = 0;

  boundary_tag_first_fit_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // watches both channels, keeps the shadow heap and the expected words
  heap_grant_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .mismatches (mismatches),
    .owed       (owed)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result words taken so far, used to time the long receiver hold
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) results_taken++;
  end

  // idle cycles before the next word: mostly none or short, a few long,
  // and now and then a run of back-to-back words
  function automatic int sender_gap();
    int roll;
    if (send_run > 0) begin
      send_run--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      send_run = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // the field an action ignores still carries random bits
  function automatic in_word_t make_word(logic act, int req, int off);
    in_word_t w;
    w.action         = act;
    w.request_bytes  = (act == ACT_ALLOC) ? FIELD_W'(req) : FIELD_W'($urandom_range(0, 8191));
    w.payload_offset = (act == ACT_FREE) ? FIELD_W'(off) : FIELD_W'($urandom_range(0, 8191));
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken;
  // in_valid stays high across back-to-back words
  task automatic send_word(in_word_t w);
    int gap;
    // a free that would send a later walk into never-written tags becomes a
    // plain free of some in-use block
    if (w.action == ACT_FREE && !u_chk.free_keeps_heap_readable(int'(w.payload_offset)))
      w.payload_offset = FIELD_W'(u_chk.pick_block_payload(1'b0));
    gap = sender_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly small allocations and frees of live blocks; the rest are big
  // requests, unaligned frees, frees past a footer and stray offsets
  function automatic in_word_t random_word();
    int roll, off;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) return make_word(ACT_ALLOC, $urandom_range(0, 64), 0);
      if (roll < 92) return make_word(ACT_ALLOC, $urandom_range(0, 1023), 0);
      return make_word(ACT_ALLOC, $urandom_range(0, 8191), 0);
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) off = u_chk.pick_block_payload(1'b0);
    else if (roll < 72) off = u_chk.pick_block_payload(1'b0) + $urandom_range(1, 7);
    else if (roll < 82) off = u_chk.pick_block_payload(1'b1);
    else if (roll < 86) off = $urandom_range(0, 7);
    else off = $urandom_range(8, 8191);
    return make_word(ACT_FREE, 0, off);
  endfunction

  // receiver: random stalls, runs of steady ready, and one long hold so the
  // block backs up and drops in_ready while words keep coming
  initial begin : result_sink
    int roll, hold, run;
    bit long_hold_done;
    run            = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      hold = 0;
      roll = $urandom_range(0, 99);
      if (!long_hold_done && results_taken >= 300) begin
        long_hold_done = 1'b1;
        hold           = 2000;
      end else if (run > 0) begin
        run--;
      end else if (roll < 5) begin
        run = $urandom_range(30, 120);
      end else if (roll < 38) begin
        hold = $urandom_range(1, 3);
      end else if (roll < 42) begin
        hold = $urandom_range(10, 40);
      end
      out_ready = (hold == 0);
      if (hold > 1) repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // pack the heap end: big block, then 40 and 24 byte blocks, 24 bytes spare
    send_word(make_word(ACT_ALLOC, 8080, 0));
    send_word(make_word(ACT_ALLOC, 16, 0));
    send_word(make_word(ACT_ALLOC, 0, 0));
    // largest request, no fit
    send_word(make_word(ACT_ALLOC, 8191, 8191));
    // free past the 40 byte block's footer: its size lands on the last header
    send_word(make_word(ACT_FREE, 0, 8144));
    // walk now meets a tag that runs past the heap end
    send_word(make_word(ACT_ALLOC, 0, 0));
    // release the big block and carve it up
    send_word(make_word(ACT_FREE, 8191, 8));
    send_word(make_word(ACT_ALLOC, 0, 0));
    send_word(make_word(ACT_ALLOC, 1, 0));
    send_word(make_word(ACT_ALLOC, 7, 0));
    send_word(make_word(ACT_ALLOC, 8, 0));
    send_word(make_word(ACT_ALLOC, 9, 0));
    // exact-size reuse, no split
    send_word(make_word(ACT_FREE, 0, 8));
    send_word(make_word(ACT_ALLOC, 0, 0));
    // offsets below 8 are ignored
    send_word(make_word(ACT_FREE, 0, 0));
    send_word(make_word(ACT_FREE, 8191, 7));
    // unaligned free, then a request the freed block is too small for
    send_word(make_word(ACT_FREE, 0, 35));
    send_word(make_word(ACT_ALLOC, 16, 0));
    // double free, then a free past a footer
    send_word(make_word(ACT_FREE, 0, 32));
    send_word(make_word(ACT_FREE, 0, 72));
    send_word(make_word(ACT_ALLOC, 4000, 0));
    send_word(make_word(ACT_FREE, 0, 184));
    send_word(make_word(ACT_ALLOC, 3880, 0));
    send_word(make_word(ACT_ALLOC, 8191, 0));

    for (i = 0; i < N_RANDOM; i++) begin
      // halfway: stop sending until every expected word is back
      if (i == N_RANDOM / 2) begin
        in_valid = 1'b0;
        while (owed != 0) @(negedge clk);
      end
      send_word(random_word());
    end
    in_valid = 1'b0;

    // drain, then leave room for any stray word
    while (owed != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> boundary_tag_first_fit_allocator_core.f
src/btfa_pkg.sv
src/btfa_ram.sv
src/btfa_alu.sv
src/btfa_seq.sv
src/boundary_tag_first_fit_allocator_core.sv
src/btfa_chk.sv
test/heap_grant_checker.sv
test/tb.sv
